>>> hdl/spq_pkg.sv
// Shared types and codes for the sphere point query solver.
`timescale 1ns / 1ps

package spq_pkg;

   typedef enum logic [1:0] {
      OP_INSIDE  = 2'd0,
      OP_SOLVE_X = 2'd1,
      OP_SOLVE_Y = 2'd2,
      OP_SOLVE_Z = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   neg;
      logic   in_sphere;
      logic   pos;
   } meta_type;

endpackage

>>> hdl/spq_front.sv
// Front stages: centre offsets, squares, inside test and discriminant.
`timescale 1ns / 1ps

module spq_front #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [1:0]                      in_op,
   input  logic signed [COORD_WIDTH-1:0]   coord_x,
   input  logic signed [COORD_WIDTH-1:0]   coord_y,
   input  logic signed [COORD_WIDTH-1:0]   coord_z,
   input  logic                            in_neg,
   input  logic signed [COORD_WIDTH-1:0]   center_x,
   input  logic signed [COORD_WIDTH-1:0]   center_y,
   input  logic signed [COORD_WIDTH-1:0]   center_z,
   input  logic [COORD_WIDTH-2:0]          radius,
   output spq_pkg::meta_type               meta,
   output logic [2*COORD_WIDTH-3:0]        rem
);

   localparam int DW   = COORD_WIDTH + 1;
   localparam int SQW  = 2 * COORD_WIDTH;
   localparam int SUMW = 2 * COORD_WIDTH + 2;
   localparam int RW   = 2 * COORD_WIDTH - 2;

   spq_pkg::meta_type      s1_meta_ff, s1_meta_in;
   logic signed [DW-1:0]   dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0]   dx_in, dy_in, dz_in;

   spq_pkg::meta_type      s2_meta_ff;
   logic [SQW-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic [RW-1:0]          r2_ff;
   logic signed [2*DW-1:0] prod_x, prod_y, prod_z;
   logic [RW-1:0]          r2_in;

   spq_pkg::meta_type      s3_meta_ff, s3_meta_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [SQW-1:0]         sq_a, sq_b;
   logic [SUMW-1:0]        sum3;
   logic [SUMW-1:0]        disc;

   assign dx_in = DW'(coord_x) - DW'(center_x);
   assign dy_in = DW'(coord_y) - DW'(center_y);
   assign dz_in = DW'(coord_z) - DW'(center_z);

   always_comb begin
      s1_meta_in        = '0;
      s1_meta_in.valid  = in_valid;
      s1_meta_in.op     = spq_pkg::op_type'(in_op);
      s1_meta_in.neg    = in_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_meta_ff <= s1_meta_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         dz_ff      <= dz_in;
      end
   end

   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;
   assign prod_z = dz_ff * dz_ff;
   assign r2_in  = RW'(radius) * RW'(radius);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_meta_ff <= s1_meta_ff;
         sqx_ff     <= prod_x[SQW-1:0];
         sqy_ff     <= prod_y[SQW-1:0];
         sqz_ff     <= prod_z[SQW-1:0];
         r2_ff      <= r2_in;
      end
   end

   always_comb begin
      unique case (s2_meta_ff.op)
         spq_pkg::OP_SOLVE_X: begin
            sq_a = sqy_ff;
            sq_b = sqz_ff;
         end
         spq_pkg::OP_SOLVE_Y: begin
            sq_a = sqx_ff;
            sq_b = sqz_ff;
         end
         default: begin
            sq_a = sqx_ff;
            sq_b = sqy_ff;
         end
      endcase
   end

   assign sum3 = SUMW'(sqx_ff) + SUMW'(sqy_ff) + SUMW'(sqz_ff);
   assign disc = SUMW'(r2_ff) - SUMW'(sq_a) - SUMW'(sq_b);

   always_comb begin
      s3_meta_in           = s2_meta_ff;
      s3_meta_in.in_sphere = 1'b0;
      s3_meta_in.pos       = 1'b0;
      if (s2_meta_ff.op == spq_pkg::OP_INSIDE) begin
         s3_meta_in.in_sphere = (sum3 <= SUMW'(r2_ff));
      end else begin
         s3_meta_in.pos = !disc[SUMW-1] && (disc != '0);
      end
      rem_in = s3_meta_in.pos ? disc[RW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_meta_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_meta_ff <= s3_meta_in;
         rem_ff     <= rem_in;
      end
   end

   assign meta = s3_meta_ff;
   assign rem  = rem_ff;

endmodule

>>> hdl/spq_sqrt_cell.sv
// One cell of the square root chain: settles a single root bit.
`timescale 1ns / 1ps

module spq_sqrt_cell #(
   parameter int RW  = 46,
   parameter int QW  = 23,
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  spq_pkg::meta_type prev_meta,
   input  logic [RW-1:0]     prev_rem,
   input  logic [QW-1:0]     prev_root,
   output spq_pkg::meta_type meta,
   output logic [RW-1:0]     rem,
   output logic [QW-1:0]     root
);

   spq_pkg::meta_type meta_ff;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     root_ff, root_in;
   logic [RW:0]       trial;
   logic              take;

   // The trial value is (root + 2^BIT)^2 - root^2 with the higher root bits in place.
   assign trial = ((RW+1)'(prev_root) << (BIT + 1)) | ((RW+1)'(1) << (2 * BIT));
   assign take  = {1'b0, prev_rem} >= trial;

   assign rem_in  = take ? (prev_rem - trial[RW-1:0]) : prev_rem;
   assign root_in = take ? (prev_root | (QW'(1) << BIT)) : prev_root;

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else if (advance) begin
         meta_ff <= prev_meta;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign meta = meta_ff;
   assign rem  = rem_ff;
   assign root = root_ff;

endmodule

>>> hdl/sphere_point_query_solver.sv
// Top level of the sphere point query solver.
// The sphere centre and radius are set through the csr_ port, one register per
// write; the user must set them only while no transaction is in flight, which
// the block does not check. Each req_ transaction is one query: operation zero
// tests whether the point lies inside or on the sphere, the others solve the
// missing x, y or z coordinate on the surface. Every query yields exactly one
// rsp_ transaction, in order. The pipeline has three front stages for offsets,
// squares and discriminant, one cell per root bit in the square root chain, and
// the output register. One query is taken every cycle while req_stall is low.
// The whole pipeline advances together; it holds only when a result waits in
// the output register and rsp_stall is high, and req_stall is raised for
// exactly those cycles. A stalled result stays unchanged on the rsp_ ports.
// Synchronous reset empties the pipeline and clears the centre and radius.
`timescale 1ns / 1ps

module sphere_point_query_solver #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_write_enable,
   input  logic [spq_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_write_data,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_operation,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]          req_coord_z,
   input  logic                                   req_negative_root,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_inside_res,
   output logic                                   rsp_solution_valid,
   output logic signed [COORD_WIDTH-1:0]          rsp_solution
);

   localparam int RW = 2 * COORD_WIDTH - 2;
   localparam int QW = COORD_WIDTH - 1;

   logic signed [COORD_WIDTH-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [COORD_WIDTH-2:0]        radius_ff;

   logic                          advance;

   spq_pkg::meta_type             chain_meta [0:QW];
   logic [RW-1:0]                 chain_rem  [0:QW];
   logic [QW-1:0]                 chain_root [0:QW];

   spq_pkg::meta_type             last_meta;
   logic signed [COORD_WIDTH-1:0] ctr;
   logic signed [COORD_WIDTH:0]   ctr_ext, root_ext, sum;
   logic signed [COORD_WIDTH-1:0] sat;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_inside_ff, rsp_inside_in;
   logic                          rsp_sol_valid_ff, rsp_sol_valid_in;
   logic signed [COORD_WIDTH-1:0] rsp_solution_ff, rsp_solution_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (spq_pkg::csr_index_type'(csr_index))
            spq_pkg::CSR_CENTER_X: center_x_ff <= csr_write_data;
            spq_pkg::CSR_CENTER_Y: center_y_ff <= csr_write_data;
            spq_pkg::CSR_CENTER_Z: center_z_ff <= csr_write_data;
            spq_pkg::CSR_RADIUS:   radius_ff   <= csr_write_data[COORD_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   spq_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_op    (req_operation),
      .coord_x  (req_coord_x),
      .coord_y  (req_coord_y),
      .coord_z  (req_coord_z),
      .in_neg   (req_negative_root),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .radius   (radius_ff),
      .meta     (chain_meta[0]),
      .rem      (chain_rem[0])
   );

   assign chain_root[0] = '0;

   for (genvar j = 0; j < QW; j++) begin : g_cell
      spq_sqrt_cell #(
         .RW  (RW),
         .QW  (QW),
         .BIT (QW - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_meta (chain_meta[j]),
         .prev_rem  (chain_rem[j]),
         .prev_root (chain_root[j]),
         .meta      (chain_meta[j+1]),
         .rem       (chain_rem[j+1]),
         .root      (chain_root[j+1])
      );
   end

   assign last_meta = chain_meta[QW];

   always_comb begin
      unique case (last_meta.op)
         spq_pkg::OP_SOLVE_X: ctr = center_x_ff;
         spq_pkg::OP_SOLVE_Y: ctr = center_y_ff;
         default:             ctr = center_z_ff;
      endcase
   end

   assign ctr_ext  = (COORD_WIDTH+1)'(ctr);
   assign root_ext = signed'((COORD_WIDTH+1)'(chain_root[QW]));
   assign sum      = last_meta.neg ? (ctr_ext - root_ext) : (ctr_ext + root_ext);

   always_comb begin
      if (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]) begin
         sat = sum[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         sat = sum[COORD_WIDTH-1:0];
      end
   end

   assign rsp_valid_in     = last_meta.valid;
   assign rsp_inside_in    = last_meta.in_sphere;
   assign rsp_sol_valid_in = last_meta.pos;
   assign rsp_solution_in  = last_meta.pos ? sat : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff     <= rsp_valid_in;
         rsp_inside_ff    <= rsp_inside_in;
         rsp_sol_valid_ff <= rsp_sol_valid_in;
         rsp_solution_ff  <= rsp_solution_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inside_res     = rsp_inside_ff;
   assign rsp_solution_valid = rsp_sol_valid_ff;
   assign rsp_solution       = rsp_solution_ff;

endmodule

>>> bench/tb_sphere_point_query_solver.sv
// Self-checking testbench for the sphere point query solver, with a scoreboard class.
`timescale 1ns / 1ps

module tb_sphere_point_query_solver;

   localparam int CW = 24;
   localparam int LATENCY = CW + 3;
   localparam int CYCLE_LIMIT = 200000;
   localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) << (CW - 1));

   typedef struct packed {
      spq_pkg::op_type        op;
      logic signed [CW-1:0]   x;
      logic signed [CW-1:0]   y;
      logic signed [CW-1:0]   z;
      logic                   neg;
   } sphere_query_type;

   typedef struct packed {
      logic                   in_sphere;
      logic                   valid;
      logic signed [CW-1:0]   solution;
   } sphere_answer_type;

   class sphere_scoreboard_type;
      logic signed [CW-1:0] centre_x;
      logic signed [CW-1:0] centre_y;
      logic signed [CW-1:0] centre_z;
      logic [CW-2:0]        radius_raw;
      sphere_answer_type    expected_answers[$];
      int errors;
      int queries_noted;
      int inside_hits;
      int solutions_valid;
      int saturations;

      function new();
         centre_x = '0;
         centre_y = '0;
         centre_z = '0;
         radius_raw = '0;
         errors = 0;
         queries_noted = 0;
         inside_hits = 0;
         solutions_valid = 0;
         saturations = 0;
      endfunction

      function void set_register(spq_pkg::csr_index_type idx, logic [CW-1:0] data);
         case (idx)
            spq_pkg::CSR_CENTER_X: centre_x = data;
            spq_pkg::CSR_CENTER_Y: centre_y = data;
            spq_pkg::CSR_CENTER_Z: centre_z = data;
            spq_pkg::CSR_RADIUS:   radius_raw = data[CW-2:0];
            default: ;
         endcase
      endfunction

      function longint floor_root(longint v);
         longint r;
         longint t;
         r = 0;
         for (int b = CW - 1; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function sphere_answer_type solve_query(sphere_query_type q);
         longint dx, dy, dz, r2, disc, ctr, root, sol;
         sphere_answer_type a;
         a = '0;
         dx = longint'(q.x) - longint'(centre_x);
         dy = longint'(q.y) - longint'(centre_y);
         dz = longint'(q.z) - longint'(centre_z);
         r2 = longint'(radius_raw) * longint'(radius_raw);
         if (q.op == spq_pkg::OP_INSIDE) begin
            a.in_sphere = (dx * dx + dy * dy + dz * dz <= r2);
         end else begin
            case (q.op)
               spq_pkg::OP_SOLVE_X: begin
                  disc = r2 - dy * dy - dz * dz;
                  ctr = longint'(centre_x);
               end
               spq_pkg::OP_SOLVE_Y: begin
                  disc = r2 - dx * dx - dz * dz;
                  ctr = longint'(centre_y);
               end
               default: begin
                  disc = r2 - dx * dx - dy * dy;
                  ctr = longint'(centre_z);
               end
            endcase
            if (disc > 0) begin
               root = floor_root(disc);
               a.valid = 1'b1;
               sol = q.neg ? ctr - root : ctr + root;
               if (sol > COORD_MAX || sol < COORD_MIN) saturations++;
               if (sol > COORD_MAX) sol = COORD_MAX;
               if (sol < COORD_MIN) sol = COORD_MIN;
               a.solution = sol[CW-1:0];
            end
         end
         return a;
      endfunction

      function void note_query(sphere_query_type q);
         sphere_answer_type a;
         a = solve_query(q);
         queries_noted++;
         if (a.in_sphere) inside_hits++;
         if (a.valid) solutions_valid++;
         expected_answers.push_back(a);
      endfunction

      function void check_answer(sphere_answer_type got);
         sphere_answer_type want;
         if (expected_answers.size() == 0) begin
            $error("Response transaction arrived with no query outstanding.");
            errors++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.in_sphere !== want.in_sphere) begin
            $error("rsp_inside_res mismatch: expected %0d, actual %0d",
                   want.in_sphere, got.in_sphere);
            errors++;
         end
         if (got.valid !== want.valid) begin
            $error("rsp_solution_valid mismatch: expected %0d, actual %0d",
                   want.valid, got.valid);
            errors++;
         end
         if (got.solution !== want.solution) begin
            $error("rsp_solution mismatch: expected %0d, actual %0d",
                   want.solution, got.solution);
            errors++;
         end
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [spq_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CW-1:0]          csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_operation;
   logic signed [CW-1:0]   req_coord_x;
   logic signed [CW-1:0]   req_coord_y;
   logic signed [CW-1:0]   req_coord_z;
   logic                   req_negative_root;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_inside_res;
   logic                   rsp_solution_valid;
   logic signed [CW-1:0]   rsp_solution;

   sphere_scoreboard_type sb;
   int send_idle_pct;
   int recv_stall_pct;
   int settings_seen;
   int cycle_count;

   sphere_point_query_solver #(
      .COORD_WIDTH(CW)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_negative_root  (req_negative_root),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_solution_valid (rsp_solution_valid),
      .rsp_solution       (rsp_solution)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      sphere_query_type q;
      if (!reset && req_valid && !req_stall) begin
         q.op = spq_pkg::op_type'(req_operation);
         q.x = req_coord_x;
         q.y = req_coord_y;
         q.z = req_coord_z;
         q.neg = req_negative_root;
         sb.note_query(q);
      end
   end

   always @(posedge clock) begin
      sphere_answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.in_sphere = rsp_inside_res;
         got.valid = rsp_solution_valid;
         got.solution = rsp_solution;
         sb.check_answer(got);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic sphere_query_type make_query(spq_pkg::op_type op, logic [CW-1:0] x,
                                                  logic [CW-1:0] y, logic [CW-1:0] z,
                                                  logic neg);
      sphere_query_type q;
      q.op = op;
      q.x = x;
      q.y = y;
      q.z = z;
      q.neg = neg;
      return q;
   endfunction

   function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] c);
      longint off;
      longint v;
      off = longint'($urandom_range(sb.radius_raw));
      if ($urandom_range(1) == 1) off = -off;
      v = longint'(c) + off;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[CW-1:0];
   endfunction

   // Most queries land within the radius of the centre so that solves usually succeed.
   function automatic sphere_query_type random_query();
      sphere_query_type q;
      q.op = spq_pkg::op_type'($urandom_range(3));
      q.neg = 1'($urandom_range(1));
      if ($urandom_range(99) < 75) begin
         q.x = near_coord(sb.centre_x);
         q.y = near_coord(sb.centre_y);
         q.z = near_coord(sb.centre_z);
      end else begin
         q.x = CW'($urandom);
         q.y = CW'($urandom);
         q.z = CW'($urandom);
      end
      return q;
   endfunction

   task automatic send_query(sphere_query_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= q.op;
      req_coord_x <= q.x;
      req_coord_y <= q.y;
      req_coord_z <= q.z;
      req_negative_root <= q.neg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(spq_pkg::csr_index_type idx, logic [CW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      sb.set_register(idx, data);
      @(posedge clock);
   endtask

   task automatic write_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                               logic [CW-1:0] rad);
      write_register(spq_pkg::CSR_CENTER_X, cx);
      write_register(spq_pkg::CSR_CENTER_Y, cy);
      write_register(spq_pkg::CSR_CENTER_Z, cz);
      write_register(spq_pkg::CSR_RADIUS, rad);
      csr_write_enable <= 1'b0;
      settings_seen++;
   endtask

   initial begin
      sb = new();
      settings_seen = 1;
      send_idle_pct = 11;
      recv_stall_pct = 72;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= spq_pkg::CSR_CENTER_X;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_operation <= spq_pkg::OP_INSIDE;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      req_negative_root <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The sphere after reset is a single point at the origin.
      send_query(make_query(spq_pkg::OP_INSIDE, '0, '0, '0, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_X, '0, '0, '0, 1'b0));
      drain();

      write_sphere(CW'(1000), CW'(-2000), CW'(3000), CW'(8192));
      send_query(make_query(spq_pkg::OP_INSIDE, CW'(1000), CW'(-2000), CW'(3000), 1'b0));
      send_query(make_query(spq_pkg::OP_INSIDE, CW'(9192), CW'(-2000), CW'(3000), 1'b0));
      send_query(make_query(spq_pkg::OP_INSIDE, CW'(9193), CW'(-2000), CW'(3000), 1'b1));
      send_query(make_query(spq_pkg::OP_SOLVE_X, 24'h7FFFFF, CW'(-2000), CW'(3000), 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_X, '0, CW'(-2000), CW'(3000), 1'b1));
      send_query(make_query(spq_pkg::OP_SOLVE_Y, CW'(9192), '0, CW'(3000), 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Z, CW'(9200), CW'(-2000), '0, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Z, CW'(1003), CW'(-1993), 24'h800000, 1'b1));
      send_query(make_query(spq_pkg::OP_INSIDE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
      send_query(make_query(spq_pkg::OP_INSIDE, 24'h800000, 24'h800000, 24'h800000, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Y, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
      drain();

      // The top radius bit is written set and must be dropped.
      write_sphere(24'h7FFFFF, 24'h800000, '0, 24'hFFFFFF);
      send_query(make_query(spq_pkg::OP_SOLVE_X, '0, 24'h800000, '0, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Y, 24'h7FFFFF, '0, '0, 1'b1));
      send_query(make_query(spq_pkg::OP_SOLVE_Y, 24'h7FFFFF, '0, '0, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Z, 24'h7FFFFF, 24'h800000, '0, 1'b0));
      send_query(make_query(spq_pkg::OP_SOLVE_Z, 24'h7FFFFF, 24'h800000, '0, 1'b1));
      send_query(make_query(spq_pkg::OP_INSIDE, '0, '0, '0, 1'b0));
      send_query(make_query(spq_pkg::OP_INSIDE, 24'h7FFFFF, 24'h800000, 24'h800000, 1'b0));

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: write_sphere(CW'($urandom), CW'($urandom), CW'($urandom),
                            CW'($urandom_range(4096 * 64)));
            1: write_sphere('0, '0, '0, 24'h7FFFFF);
            2: write_sphere(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
            3: write_sphere(24'h800000, 24'h800000, 24'h800000, CW'(1));
            4: write_sphere(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
            default: write_sphere(CW'($urandom), CW'($urandom), CW'($urandom), '0);
         endcase
         if (p < 2) begin
            send_idle_pct = 11;
            recv_stall_pct = 72;
         end else if (p < 4) begin
            send_idle_pct = 72;
            recv_stall_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         for (int i = 0; i < 190; i++) begin
            if (p == 1 && i == 95) drain();
            send_query(random_query());
         end
      end

      drain();
      repeat (LATENCY) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("Ran %0d queries over %0d sphere settings: %0d inside, %0d solved, %0d clamped.",
               sb.queries_noted, settings_seen, sb.inside_hits, sb.solutions_valid,
               sb.saturations);
      $display("Field mismatches and protocol errors: %0d", sb.errors);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
